FILE: design/wmv_pkg.sv
// Shared types and constants for the weighted mean and variance engine.
// Depends on nothing; used by the top level and its port list.
package wmv_pkg;

	localparam int SAMPLE_W = 16;
	localparam int WEIGHT_W = 8;
	localparam int MEAN_W = 24;
	localparam int VAR_W = 40;
	localparam int DEV_W = 24;
	localparam int COUNT_W = 11;
	localparam int FRAC_W = 8;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO_WEIGHT = 2'd1;
	localparam logic [1:0] ST_ONE_WEIGHT = 2'd2;
	localparam logic [1:0] ST_OVERFLOW = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [WEIGHT_W-1:0] weight;
		logic last;
	} in_beat_t;

	typedef struct packed {
		logic signed [MEAN_W-1:0] mean;
		logic [VAR_W-1:0] variance;
		logic [DEV_W-1:0] deviation;
		logic [COUNT_W-1:0] count;
		logic [1:0] status;
	} out_beat_t;

endpackage

FILE: design/wmv_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependency.
module wmv_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/weighted_mean_variance_engine.sv
// Top level of the weighted mean, variance and deviation engine.
// Depends on wmv_pkg and wmv_ram.
//
//  channel | signals                          | beat moves when
//  --------+----------------------------------+--------------------------
//  in      | in_valid, in_stall, in_data      | in_valid and not in_stall
//  out     | out_valid, out_stall, out_data   | out_valid and not out_stall
//  cfg     | cfg_valid, cfg_ready, cfg_data   | cfg_valid and cfg_ready
//
// A sample that is not last is written into the store while the store has room.
// A last sample starts the result: the mean division, a pass over the store, the variance
// division, the square root and the load of the result, in that order; a zero total weight
// skips straight to the load, and a total weight of one goes to it after the mean division.
// Both divisions run through one radix-2 divider, 60 bits wide at the default capacity.
// Reset clears the sums, the count and the result slot's valid flag; the store needs none.
// A result waits in the output register while the next data set is collected.
module weighted_mean_variance_engine #(
	parameter int CAPACITY = 1024
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input wmv_pkg::in_beat_t in_data,
	output logic out_valid,
	input logic out_stall,
	output wmv_pkg::out_beat_t out_data,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_data
);

	localparam int SW = wmv_pkg::SAMPLE_W;
	localparam int WW = wmv_pkg::WEIGHT_W;
	localparam int FW = wmv_pkg::FRAC_W;
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SUMW = SW + WW + 1 + AW;
	localparam int TWW = WW + AW + 1;
	localparam int MW = SW + FW;
	localparam int DLW = SW + FW + 1;
	localparam int SQW = 2 * DLW;
	localparam int PRW = SQW + WW;
	localparam int ACCW = PRW + AW;
	localparam int DIVW = (SUMW + FW > ACCW - FW) ? SUMW + FW : ACCW - FW;
	localparam int DCW = $clog2(DIVW + 1);
	localparam int VW = wmv_pkg::VAR_W;
	localparam int DVW = wmv_pkg::DEV_W;
	localparam int RADW = 2 * DVW;
	localparam int SRW = DVW + 2;
	localparam int SCW = $clog2(DVW + 1);

	typedef enum logic [2:0] {
		S_COLLECT, S_MEAN, S_DIVM, S_PASS, S_DIVV, S_SQRT, S_DONE
	} state_t;

	state_t state_q;
	logic use_weights_q;
	logic [CW-1:0] cnt_q;
	logic signed [SUMW-1:0] ws_q;
	logic [TWW-1:0] tw_q;
	logic ovf_q;
	logic out_valid_q;
	wmv_pkg::out_beat_t out_q;

	logic in_fire;
	logic full;
	logic [WW-1:0] w_eff;
	logic signed [SW+WW:0] prod_in;
	logic load_out;

	// Shared divider.
	logic [TWW-1:0] dv_rem_q;
	logic [TWW-1:0] dv_dsr_q;
	logic [DIVW-1:0] dv_dvd_q;
	logic [DIVW-1:0] dv_quo_q;
	logic [DCW-1:0] dv_cnt_q;
	logic [TWW:0] dv_sh;
	logic dv_ge;
	logic [TWW:0] dv_diff;

	// Square root unit.
	logic [RADW-1:0] sq_val_q;
	logic [SRW-1:0] sq_rem_q;
	logic [DVW-1:0] sq_root_q;
	logic [SCW-1:0] sq_cnt_q;
	logic [SRW:0] sq_sh;
	logic [SRW:0] sq_trial;
	logic sq_ge;
	logic [SRW:0] sq_diff;

	// Second pass pipeline.
	logic [CW-1:0] ridx_q;
	logic issue;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [SW+WW-1:0] rdata;
	logic [DLW-1:0] ad_s2;
	logic [WW-1:0] w_s2, w_s3;
	logic [SQW-1:0] sq_s3;
	logic [PRW-1:0] pr_s4;
	logic [ACCW-1:0] acc_q;
	logic signed [DLW-1:0] dl;

	logic signed [MW-1:0] mean_q;
	logic [VW-1:0] var_q;
	logic [DVW-1:0] dev_q;
	logic ws_neg;
	logic [SUMW-1:0] ws_mag;
	logic [1:0] status;

	assign in_stall = (state_q != S_COLLECT);
	assign in_fire = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign full = (cnt_q == CW'(CAPACITY));
	assign w_eff = use_weights_q ? in_data.weight : WW'(1);
	assign prod_in = in_data.sample * $signed({1'b0, w_eff});
	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// Sample store: sample and weight side by side in one word.
	wmv_ram #(
		.WIDTH(SW + WW),
		.DEPTH(CAPACITY)
	) u_store (
		.clk(clk),
		.we(in_fire && !full),
		.waddr(cnt_q[AW-1:0]),
		.wdata({in_data.sample, w_eff}),
		.raddr(ridx_q[AW-1:0]),
		.rdata(rdata)
	);

	// Divider step: one quotient bit a cycle.
	assign dv_sh = {dv_rem_q, dv_dvd_q[DIVW-1]};
	assign dv_ge = (dv_sh >= {1'b0, dv_dsr_q});
	assign dv_diff = dv_sh - {1'b0, dv_dsr_q};

	// Square root step: two radicand bits a cycle.
	assign sq_sh = {sq_rem_q[SRW-2:0], sq_val_q[RADW-1:RADW-2]};
	assign sq_trial = {1'b0, sq_root_q, 2'b01};
	assign sq_ge = (sq_sh >= sq_trial);
	assign sq_diff = sq_sh - sq_trial;

	assign ws_neg = ws_q[SUMW-1];
	assign ws_mag = ws_neg ? SUMW'(-ws_q) : SUMW'(ws_q);
	assign issue = (state_q == S_PASS) && (ridx_q < cnt_q);
	assign dl = DLW'($signed({rdata[SW+WW-1:WW], FW'(0)})) - DLW'(mean_q);

	// Status in priority order.
	always_comb begin
		if (tw_q == '0) begin
			status = wmv_pkg::ST_ZERO_WEIGHT;
		end else if (tw_q == TWW'(1)) begin
			status = wmv_pkg::ST_ONE_WEIGHT;
		end else if (ovf_q) begin
			status = wmv_pkg::ST_OVERFLOW;
		end else begin
			status = wmv_pkg::ST_OK;
		end
	end

	// Sequencer, running sums and the result slot's valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLLECT;
			use_weights_q <= 1'b0;
			cnt_q <= '0;
			ws_q <= '0;
			tw_q <= '0;
			ovf_q <= 1'b0;
			out_valid_q <= 1'b0;
			ridx_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			dv_cnt_q <= '0;
			sq_cnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				use_weights_q <= cfg_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			case (state_q)
				S_COLLECT: begin
					if (in_fire) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							cnt_q <= cnt_q + CW'(1);
							ws_q <= ws_q + SUMW'(prod_in);
							tw_q <= tw_q + TWW'(w_eff);
						end
						if (in_data.last) begin
							state_q <= S_MEAN;
						end
					end
				end
				S_MEAN: begin
					if (tw_q == '0) begin
						state_q <= S_DONE;
					end else begin
						dv_cnt_q <= DCW'(DIVW);
						state_q <= S_DIVM;
					end
				end
				S_DIVM: begin
					if (dv_cnt_q != '0) begin
						dv_cnt_q <= dv_cnt_q - DCW'(1);
					end else if (tw_q == TWW'(1)) begin
						state_q <= S_DONE;
					end else begin
						ridx_q <= '0;
						state_q <= S_PASS;
					end
				end
				S_PASS: begin
					if (issue) begin
						ridx_q <= ridx_q + CW'(1);
					end else if (!v_s1 && !v_s2 && !v_s3 && !v_s4) begin
						dv_cnt_q <= DCW'(DIVW);
						state_q <= S_DIVV;
					end
				end
				S_DIVV: begin
					if (dv_cnt_q != '0) begin
						dv_cnt_q <= dv_cnt_q - DCW'(1);
					end else begin
						sq_cnt_q <= SCW'(DVW);
						state_q <= S_SQRT;
					end
				end
				S_SQRT: begin
					if (sq_cnt_q != '0) begin
						sq_cnt_q <= sq_cnt_q - SCW'(1);
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						cnt_q <= '0;
						ws_q <= '0;
						tw_q <= '0;
						ovf_q <= 1'b0;
						state_q <= S_COLLECT;
					end
				end
				default: begin
					state_q <= S_COLLECT;
				end
			endcase
		end
	end

	// Datapath: divider, square root, pass pipeline and result fields.
	always_ff @(posedge clk) begin
		ad_s2 <= dl[DLW-1] ? DLW'(-dl) : DLW'(dl);
		w_s2 <= rdata[WW-1:0];
		sq_s3 <= SQW'(ad_s2) * SQW'(ad_s2);
		w_s3 <= w_s2;
		pr_s4 <= PRW'(sq_s3) * PRW'(w_s3);
		if (v_s4) begin
			acc_q <= acc_q + ACCW'(pr_s4);
		end
		case (state_q)
			S_MEAN: begin
				mean_q <= '0;
				var_q <= '0;
				dev_q <= '0;
				dv_rem_q <= '0;
				dv_dsr_q <= tw_q;
				dv_dvd_q <= DIVW'({ws_mag, FW'(0)});
			end
			S_DIVM, S_DIVV: begin
				if (dv_cnt_q != '0) begin
					dv_rem_q <= dv_ge ? dv_diff[TWW-1:0] : dv_sh[TWW-1:0];
					dv_quo_q <= {dv_quo_q[DIVW-2:0], dv_ge};
					dv_dvd_q <= {dv_dvd_q[DIVW-2:0], 1'b0};
				end else if (state_q == S_DIVM) begin
					mean_q <= ws_neg ? -MW'(dv_quo_q) : MW'(dv_quo_q);
					acc_q <= '0;
				end else begin
					var_q <= (|dv_quo_q[DIVW-1:VW]) ? {VW{1'b1}} : dv_quo_q[VW-1:0];
					sq_val_q <= {(|dv_quo_q[DIVW-1:VW]) ? {VW{1'b1}} : dv_quo_q[VW-1:0],
						FW'(0)};
					sq_rem_q <= '0;
					sq_root_q <= '0;
				end
			end
			S_PASS: begin
				if (!issue && !v_s1 && !v_s2 && !v_s3 && !v_s4) begin
					dv_rem_q <= '0;
					dv_dsr_q <= tw_q - TWW'(1);
					dv_dvd_q <= DIVW'(acc_q >> FW);
				end
			end
			S_SQRT: begin
				if (sq_cnt_q != '0) begin
					sq_rem_q <= sq_ge ? sq_diff[SRW-1:0] : sq_sh[SRW-1:0];
					sq_root_q <= {sq_root_q[DVW-2:0], sq_ge};
					sq_val_q <= {sq_val_q[RADW-3:0], 2'b00};
				end else begin
					dev_q <= sq_root_q;
				end
			end
			S_DONE: begin
				if (load_out) begin
					out_q.mean <= wmv_pkg::MEAN_W'(mean_q);
					out_q.variance <= var_q;
					out_q.deviation <= dev_q;
					out_q.count <= wmv_pkg::COUNT_W'(cnt_q);
					out_q.status <= status;
				end
			end
			default: begin
			end
		endcase
	end

	// The fill count never passes the store's depth.
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(CAPACITY))
		else $error("sample count beyond capacity");

	// Store reads only move through the pipeline during the second pass.
	assert property (@(posedge clk) disable iff (!arst_n) v_s1 |-> state_q == S_PASS)
		else $error("store read outside the second pass");

	// A beat that finds the store full raises the overflow flag.
	assert property (@(posedge clk) disable iff (!arst_n) (in_fire && full) |=> ovf_q)
		else $error("dropped beat did not flag overflow");

	// A result is only loaded while the slot is free or being emptied.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && out_stall) |=> state_q == S_DONE)
		else $error("result loaded over a waiting beat");

endmodule

FILE: dv/weighted_mean_variance_engine_tb.sv
// Self-checking testbench for the weighted mean, variance and deviation engine.
// Depends on wmv_pkg and the engine RTL; predicts each result and compares every field.
module weighted_mean_variance_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 1024;
	localparam int SW = wmv_pkg::SAMPLE_W;
	localparam int WW = wmv_pkg::WEIGHT_W;
	localparam int DVW = wmv_pkg::DEV_W;
	localparam int VW = wmv_pkg::VAR_W;
	localparam int MNW = wmv_pkg::MEAN_W;
	localparam int CNW = wmv_pkg::COUNT_W;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	wmv_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	wmv_pkg::out_beat_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_data = 1'b0;

	// Predictor state: a copy of the store, the running sums and the register.
	logic signed [SW-1:0] pred_samples [DEPTH];
	logic [WW-1:0] pred_weights [DEPTH];
	int unsigned pred_count;
	longint pred_sum;
	longint unsigned pred_total;
	bit pred_overflow;
	bit weights_on;

	wmv_pkg::out_beat_t pending_results [$];
	int unsigned fail_count;
	int unsigned results_seen;
	int unsigned send_idle_pct;
	int unsigned take_idle_pct;

	weighted_mean_variance_engine u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// Integer square root of a 48-bit value, bit by bit.
	function automatic logic [DVW-1:0] root_floor(logic [47:0] v);
		logic [DVW-1:0] r;
		logic [DVW-1:0] t;
		r = '0;
		for (int b = DVW - 1; b >= 0; b--) begin
			t = r | (24'd1 << b);
			if ({24'd0, t} * {24'd0, t} <= v)
				r = t;
		end
		return r;
	endfunction

	// Fold one accepted sample into the data set and queue a result on a last beat.
	task automatic fold_sample(wmv_pkg::in_beat_t b);
		logic [WW-1:0] w;
		wmv_pkg::out_beat_t res;
		longint mean_q8;
		longint unsigned mag;
		longint d;
		longint unsigned ad;
		logic [127:0] acc;
		logic [127:0] q;
		w = weights_on ? b.weight : 8'd1;
		if (pred_count < DEPTH) begin
			pred_samples[pred_count] = b.sample;
			pred_weights[pred_count] = w;
			pred_count++;
			pred_sum += longint'(b.sample) * longint'(w);
			pred_total += w;
		end else begin
			pred_overflow = 1'b1;
		end
		if (!b.last)
			return;
		res = '0;
		mean_q8 = 0;
		if (pred_total != 0) begin
			mag = (pred_sum < 0) ? -pred_sum : pred_sum;
			mag = (mag << wmv_pkg::FRAC_W) / pred_total;
			mean_q8 = (pred_sum < 0) ? -longint'(mag) : longint'(mag);
		end
		if (pred_total > 1) begin
			acc = '0;
			for (int i = 0; i < pred_count; i++) begin
				d = longint'(pred_samples[i]) * 256 - mean_q8;
				ad = (d < 0) ? -d : d;
				acc += 128'(ad) * 128'(ad) * 128'(pred_weights[i]);
			end
			q = acc / (128'(pred_total - 1) * 128'd256);
			res.variance = (q > 128'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : q[VW-1:0];
			res.deviation = root_floor({res.variance, 8'd0});
		end
		res.mean = mean_q8[MNW-1:0];
		res.count = pred_count[CNW-1:0];
		if (pred_total == 0)
			res.status = wmv_pkg::ST_ZERO_WEIGHT;
		else if (pred_total == 1)
			res.status = wmv_pkg::ST_ONE_WEIGHT;
		else if (pred_overflow)
			res.status = wmv_pkg::ST_OVERFLOW;
		else
			res.status = wmv_pkg::ST_OK;
		pending_results.push_back(res);
		pred_count = 0;
		pred_sum = 0;
		pred_total = 0;
		pred_overflow = 1'b0;
	endtask

	// Send one beat, idling beforehand at the current rate, and wait for acceptance.
	// Valid stays high afterwards so that beats can follow back to back.
	task automatic send_sample(logic signed [SW-1:0] s, logic [WW-1:0] w,
			logic lst);
		wmv_pkg::in_beat_t b;
		b.sample = s;
		b.weight = w;
		b.last = lst;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		fold_sample(b);
	endtask

	// Wait for every expected result, let the block settle, then write the register.
	task automatic write_weighting(bit on);
		int unsigned guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pending_results.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (200) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= on;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		weights_on = on;
	endtask

	// Receiver: random stall and in-order comparison of each result beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_data);
					fail_count++;
				end else begin
					if (out_data !== pending_results[0]) begin
						$display("%0t: result mismatch expected %p actual %p", $time,
							pending_results[0], out_data);
						fail_count++;
					end
					void'(pending_results.pop_front());
				end
				results_seen++;
			end
			out_stall <= ($urandom_range(99) < take_idle_pct);
		end
	end

	// Directed extremes and special cases with weighting off.
	task automatic test_unweighted_edges();
		send_sample(16'sh7FFF, 8'd0, 1'b0);
		send_sample(-16'sd32768, 8'd255, 1'b1);
		send_sample(16'sd5, 8'd3, 1'b1);
		send_sample(-16'sd7, 8'd1, 1'b0);
		send_sample(16'sd4, 8'd2, 1'b0);
		send_sample(16'sd1, 8'd9, 1'b1);
	endtask

	// Weighting on: zero, one and maximal weights, and full-scale sample values.
	task automatic test_weighted_edges();
		send_sample(16'sd100, 8'd0, 1'b1);
		send_sample(16'sd100, 8'd0, 1'b0);
		send_sample(-16'sd3, 8'd1, 1'b1);
		send_sample(16'sh7FFF, 8'd255, 1'b0);
		send_sample(-16'sd32768, 8'd255, 1'b0);
		send_sample(16'sd0, 8'd0, 1'b1);
		send_sample(-16'sd1, 8'd2, 1'b0);
		send_sample(16'sd2, 8'd1, 1'b1);
		send_sample(16'sh7FFF, 8'd255, 1'b0);
		send_sample(-16'sd32768, 8'd1, 1'b1);
	endtask

	// Fill the store past capacity so the excess beats are dropped and flagged.
	task automatic test_overflow();
		for (int i = 0; i < DEPTH + 3; i++)
			send_sample(SW'($urandom), WW'($urandom), i == DEPTH + 2);
	endtask

	// Random data sets, mostly short, with full-range sample and weight values.
	task automatic test_random_sets(int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(60, 1) : $urandom_range(8, 1);
			for (int i = 0; i < len; i++) begin
				send_sample(SW'($urandom),
					WW'(($urandom_range(3) == 0) ? $urandom_range(2) : $urandom),
					i == len - 1);
				sent++;
			end
		end
	endtask

	initial begin
		pred_count = 0;
		pred_sum = 0;
		pred_total = 0;
		pred_overflow = 1'b0;
		weights_on = 1'b0;
		fail_count = 0;
		results_seen = 0;
		send_idle_pct = 9;
		take_idle_pct = 63;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unweighted_edges();
		write_weighting(1'b1);
		test_weighted_edges();
		test_overflow();
		test_random_sets(100);
		send_idle_pct = 63;
		take_idle_pct = 9;
		write_weighting(1'b0);
		test_random_sets(50);
		write_weighting(1'b1);
		test_random_sets(50);
		send_idle_pct = 0;
		take_idle_pct = 0;
		test_random_sets(50);
		write_weighting(1'b0);
		test_random_sets(50);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("Checked %0d results over directed edges, overflow and random data sets,",
			results_seen);
		$display("with weighting on and off under varying idle and stall rates.");
		if (fail_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Watchdog.
	initial begin
		#50ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
